FILE: src/piecewise_linear_calibrator_defines.svh
// Assertion macros shared by the calibrator RTL.
`ifndef PIECEWISE_LINEAR_CALIBRATOR_DEFINES_SVH
`define PIECEWISE_LINEAR_CALIBRATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define PLC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("calibrator assertion failed");
`define PLC_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("calibrator reset assertion failed");
`else
`define PLC_ASSERT(lbl, clk, rst, prop)
`define PLC_ASSERT_NR(lbl, clk, prop)
`endif
`endif

FILE: src/plc_pkg.sv
// Types, codes and field widths of the piecewise linear calibrator.
package plc_pkg;

  localparam int X_W    = 24;
  localparam int Y_W    = 32;
  localparam int K_W    = 48;
  localparam int B_W    = 48;
  localparam int V_W    = 32;
  localparam int TOT_W  = 6;
  localparam int PART_W = 24;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_BUILD,
    OP_QUERY
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_FEW,
    ST_EQUAL
  } status_t;

  typedef struct packed {
    op_t                   operation;
    logic signed [X_W-1:0] x_raw;
    logic signed [Y_W-1:0] y_phy;
  } in_word_t;

  typedef struct packed {
    logic signed [V_W-1:0] value;
    logic                  value_valid;
    status_t               status;
    logic [TOT_W-1:0]      section_total;
  } out_word_t;

  typedef enum logic [5:0] {
    CMD_NOP,
    CMD_CAPTURE,
    CMD_CLEAR,
    CMD_APPEND,
    CMD_FEW,
    CMD_SORT_INIT,
    CMD_KEY_RD,
    CMD_KEY_LATCH,
    CMD_CMP_RD,
    CMD_SHIFT,
    CMD_INSERT,
    CMD_FIRST_RD,
    CMD_PREV_LATCH,
    CMD_PT_RD,
    CMD_CHK_NEXT,
    CMD_EQUAL,
    CMD_CUR_LATCH,
    CMD_MUL1,
    CMD_MUL2,
    CMD_DIV_SLOPE,
    CMD_SLOPE_LATCH,
    CMD_DIV_OFFSET,
    CMD_SEC_WRITE,
    CMD_BUILD_OK,
    CMD_NONE_Q,
    CMD_Q_INIT,
    CMD_Q_NEXT,
    CMD_Q_PICK,
    CMD_Q_MULHI,
    CMD_Q_MULLO,
    CMD_Q_SUM,
    CMD_Q_ADD,
    CMD_Q_SAT,
    CMD_EMIT
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic few;
    logic szero;
    logic i_end;
    logic j_zero;
    logic rd_gt_key;
    logic rd_eq_prev;
    logic div_done;
    logic q_hit;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: src/plc_ram.sv
// Generic single write port RAM with registered read.
module plc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then read registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/plc_div.sv
// Restoring divider, one quotient bit a cycle, quotient truncated toward zero.
module plc_div #(
  parameter int NUM_W = 57,
  parameter int DEN_W = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    busy,
  output logic                    done,
  output logic signed [NUM_W:0]   quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] mag;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic             neg;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  // trial subtract of the shifted remainder
  assign rem_sh = {rem, mag[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};
  assign quo    = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  // sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == CNT_W'(1)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  // shift quotient bits into the magnitude register
  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= num[NUM_W-1];
      mag   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      rem   <= '0;
      den_r <= den;
      cnt   <= CNT_W'(NUM_W);
    end else if (busy) begin
      rem <= fits ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
      mag <= {mag[NUM_W-2:0], fits};
      cnt <= cnt - CNT_W'(1);
    end
  end

endmodule

FILE: src/plc_ctrl.sv
// Controller state machine of the calibrator: sequences every operation.
module plc_ctrl import plc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH,
    S_KEY, S_KEY_W, S_CMP, S_CMP_W,
    S_C_INIT, S_C_W0, S_C_RD, S_C_W,
    S_K_INIT, S_K_W0, S_K_RD, S_K_W, S_K_M1, S_K_M2,
    S_K_D1, S_K_D1W, S_K_D2, S_K_D2W,
    S_Q_RD, S_Q_W, S_Q_M1, S_Q_M2, S_Q_SUM, S_Q_ADD, S_Q_SAT,
    S_FINISH
  } state_t;

  state_t state, state_next;

  assign item_ready = (state == S_IDLE);

  // next state and datapath command
  always_comb begin
    state_next = state;
    cmd        = CMD_NOP;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd        = CMD_CAPTURE;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.op)
          OP_CLEAR: begin
            cmd        = CMD_CLEAR;
            state_next = S_FINISH;
          end
          OP_APPEND: begin
            cmd        = CMD_APPEND;
            state_next = S_FINISH;
          end
          OP_BUILD: begin
            if (stat.few) begin
              cmd        = CMD_FEW;
              state_next = S_FINISH;
            end else begin
              cmd        = CMD_SORT_INIT;
              state_next = S_KEY;
            end
          end
          OP_QUERY: begin
            if (stat.szero) begin
              cmd        = CMD_NONE_Q;
              state_next = S_FINISH;
            end else begin
              cmd        = CMD_Q_INIT;
              state_next = S_Q_RD;
            end
          end
          default: state_next = S_FINISH;
        endcase
      end
      // insertion sort over the point memory
      S_KEY: begin
        if (stat.i_end) begin
          state_next = S_C_INIT;
        end else begin
          cmd        = CMD_KEY_RD;
          state_next = S_KEY_W;
        end
      end
      S_KEY_W: begin
        cmd        = CMD_KEY_LATCH;
        state_next = S_CMP;
      end
      S_CMP: begin
        if (stat.j_zero) begin
          cmd        = CMD_INSERT;
          state_next = S_KEY;
        end else begin
          cmd        = CMD_CMP_RD;
          state_next = S_CMP_W;
        end
      end
      S_CMP_W: begin
        if (stat.rd_gt_key) begin
          cmd        = CMD_SHIFT;
          state_next = S_CMP;
        end else begin
          cmd        = CMD_INSERT;
          state_next = S_KEY;
        end
      end
      // scan for equal neighbours
      S_C_INIT: begin
        cmd        = CMD_FIRST_RD;
        state_next = S_C_W0;
      end
      S_C_W0: begin
        cmd        = CMD_PREV_LATCH;
        state_next = S_C_RD;
      end
      S_C_RD: begin
        if (stat.i_end) begin
          state_next = S_K_INIT;
        end else begin
          cmd        = CMD_PT_RD;
          state_next = S_C_W;
        end
      end
      S_C_W: begin
        if (stat.rd_eq_prev) begin
          cmd        = CMD_EQUAL;
          state_next = S_FINISH;
        end else begin
          cmd        = CMD_CHK_NEXT;
          state_next = S_C_RD;
        end
      end
      // compute one section per neighbour pair
      S_K_INIT: begin
        cmd        = CMD_FIRST_RD;
        state_next = S_K_W0;
      end
      S_K_W0: begin
        cmd        = CMD_PREV_LATCH;
        state_next = S_K_RD;
      end
      S_K_RD: begin
        if (stat.i_end) begin
          cmd        = CMD_BUILD_OK;
          state_next = S_FINISH;
        end else begin
          cmd        = CMD_PT_RD;
          state_next = S_K_W;
        end
      end
      S_K_W: begin
        cmd        = CMD_CUR_LATCH;
        state_next = S_K_M1;
      end
      S_K_M1: begin
        cmd        = CMD_MUL1;
        state_next = S_K_M2;
      end
      S_K_M2: begin
        cmd        = CMD_MUL2;
        state_next = S_K_D1;
      end
      S_K_D1: begin
        cmd        = CMD_DIV_SLOPE;
        state_next = S_K_D1W;
      end
      S_K_D1W: begin
        if (stat.div_done) begin
          cmd        = CMD_SLOPE_LATCH;
          state_next = S_K_D2;
        end
      end
      S_K_D2: begin
        cmd        = CMD_DIV_OFFSET;
        state_next = S_K_D2W;
      end
      S_K_D2W: begin
        if (stat.div_done) begin
          cmd        = CMD_SEC_WRITE;
          state_next = S_K_RD;
        end
      end
      // query: scan sections, then evaluate
      S_Q_RD: begin
        state_next = S_Q_W;
      end
      S_Q_W: begin
        if (stat.q_hit) begin
          cmd        = CMD_Q_PICK;
          state_next = S_Q_M1;
        end else begin
          cmd        = CMD_Q_NEXT;
          state_next = S_Q_RD;
        end
      end
      S_Q_M1: begin
        cmd        = CMD_Q_MULHI;
        state_next = S_Q_M2;
      end
      S_Q_M2: begin
        cmd        = CMD_Q_MULLO;
        state_next = S_Q_SUM;
      end
      S_Q_SUM: begin
        cmd        = CMD_Q_SUM;
        state_next = S_Q_ADD;
      end
      S_Q_ADD: begin
        cmd        = CMD_Q_ADD;
        state_next = S_Q_SAT;
      end
      S_Q_SAT: begin
        cmd        = CMD_Q_SAT;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd        = CMD_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: src/plc_dp.sv
// Datapath of the calibrator: point and section memories, multiplier, divider.
`include "piecewise_linear_calibrator_defines.svh"
module plc_dp import plc_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  input  in_word_t  item,
  input  logic      result_ready,
  output logic      result_valid,
  output out_word_t result
);

  localparam int AW     = $clog2(MAX_POINTS);
  localparam int PC_W   = $clog2(MAX_POINTS + 1);
  localparam int SC_W   = AW;
  localparam int NUM_W  = (Y_W + 1 + FRAC_BITS > 57) ? Y_W + 1 + FRAC_BITS : 57;
  localparam int SH     = PART_W - FRAC_BITS;
  localparam int PT_W   = X_W + Y_W;
  localparam int SEC_W  = X_W + K_W + B_W;
  localparam int PROD_W = Y_W + 1 + X_W + 1;
  localparam int Q_W    = 52;
  localparam int R_W    = 54;
  localparam int CLAMP_EXP = 50;

  localparam logic [Q_W-1:0] CLAMP = Q_W'(1) << CLAMP_EXP;
  localparam logic [Q_W-1:0] HI_LIM = Q_W'(1) << (CLAMP_EXP - SH);
  localparam logic signed [NUM_W:0] S48_HI = {{(NUM_W-46){1'b0}}, {47{1'b1}}};
  localparam logic signed [NUM_W:0] S48_LO = {{(NUM_W-46){1'b1}}, {47{1'b0}}};
  localparam logic signed [R_W-1:0] S32_HI = {{(R_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [R_W-1:0] S32_LO = {{(R_W-31){1'b1}}, {31{1'b0}}};

  function automatic logic signed [K_W-1:0] sat48(input logic signed [NUM_W:0] v);
    logic signed [NUM_W:0] c;
    c = v;
    if (v > S48_HI) c = S48_HI;
    if (v < S48_LO) c = S48_LO;
    return c[K_W-1:0];
  endfunction

  in_word_t              in_r;
  logic [PC_W-1:0]       pcount, i, j, jm1, im1;
  logic [SC_W-1:0]       scount;
  logic signed [X_W-1:0] key_x, prev_x, cur_x;
  logic signed [Y_W-1:0] key_y, prev_y, cur_y;
  logic signed [PROD_W-1:0] mul_p, mul_hold, prod;
  logic signed [Y_W:0]   mul_a;
  logic signed [X_W:0]   mul_b;
  logic signed [K_W-1:0] slope_r;
  logic signed [B_W-1:0] b_r;
  logic [K_W-1:0]        km;
  logic [X_W-1:0]        xm;
  logic                  neg;
  logic [Q_W-1:0]        q_raw, qc;
  logic                  hi_big;
  logic signed [R_W-1:0] r_acc;
  logic signed [V_W-1:0] res_value;
  logic                  res_valid;
  status_t               res_status;
  logic [15:0]           sc_wide;

  logic                  pt_we;
  logic [AW-1:0]         pt_wa, pt_ra;
  logic [PT_W-1:0]       pt_wd, pt_rd;
  logic signed [X_W-1:0] pt_rd_x;
  logic signed [Y_W-1:0] pt_rd_y;
  logic                  sec_we;
  logic [SEC_W-1:0]      sec_wd, sec_rd;
  logic signed [X_W-1:0] sec_upper;
  logic signed [K_W-1:0] sec_slope;
  logic signed [B_W-1:0] sec_off;

  logic                  div_start, div_busy, div_done;
  logic signed [NUM_W-1:0] div_num, num_slope, num_off;
  logic signed [X_W:0]   dx;
  logic signed [Y_W:0]   dy;
  logic signed [NUM_W:0] div_quo;
  logic                  full;

  assign jm1     = j - PC_W'(1);
  assign im1     = i - PC_W'(1);
  assign full    = pcount >= PC_W'(MAX_POINTS);
  assign pt_rd_x = pt_rd[PT_W-1 -: X_W];
  assign pt_rd_y = pt_rd[Y_W-1:0];
  assign sec_upper = sec_rd[SEC_W-1 -: X_W];
  assign sec_slope = sec_rd[K_W+B_W-1 -: K_W];
  assign sec_off   = sec_rd[B_W-1:0];
  assign sc_wide   = 16'(scount);

  // point memory ports
  always_comb begin
    pt_we = 1'b0;
    pt_wa = j[AW-1:0];
    pt_wd = {key_x, key_y};
    unique case (cmd)
      CMD_APPEND: begin
        pt_we = !full;
        pt_wa = pcount[AW-1:0];
        pt_wd = {in_r.x_raw, in_r.y_phy};
      end
      CMD_SHIFT: begin
        pt_we = 1'b1;
        pt_wd = pt_rd;
      end
      CMD_INSERT: pt_we = 1'b1;
      default: ;
    endcase
  end

  assign pt_ra = (cmd == CMD_CMP_RD)   ? jm1[AW-1:0] :
                 (cmd == CMD_FIRST_RD) ? '0 : i[AW-1:0];

  plc_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
    .clk     (clk),
    .wr_en   (pt_we),
    .wr_addr (pt_wa),
    .wr_data (pt_wd),
    .rd_addr (pt_ra),
    .rd_data (pt_rd)
  );

  // section memory: upper x, slope, offset
  assign sec_we = (cmd == CMD_SEC_WRITE);
  assign sec_wd = {cur_x, slope_r, sat48(div_quo)};

  plc_ram #(.WIDTH(SEC_W), .DEPTH(MAX_POINTS)) u_sec_ram (
    .clk     (clk),
    .wr_en   (sec_we),
    .wr_addr (im1[AW-1:0]),
    .wr_data (sec_wd),
    .rd_addr (i[AW-1:0]),
    .rd_data (sec_rd)
  );

  // shared multiplier operands
  always_comb begin
    mul_a = (Y_W+1)'(prev_y);
    mul_b = (X_W+1)'(cur_x);
    unique case (cmd)
      CMD_MUL2: begin
        mul_a = (Y_W+1)'(cur_y);
        mul_b = (X_W+1)'(prev_x);
      end
      CMD_Q_MULHI: begin
        mul_a = $signed((Y_W+1)'(km[K_W-1:PART_W]));
        mul_b = $signed((X_W+1)'(xm));
      end
      CMD_Q_MULLO: begin
        mul_a = $signed((Y_W+1)'(km[PART_W-1:0]));
        mul_b = $signed((X_W+1)'(xm));
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // divider operands
  assign dx        = (X_W+1)'(cur_x) - (X_W+1)'(prev_x);
  assign dy        = (Y_W+1)'(cur_y) - (Y_W+1)'(prev_y);
  assign num_slope = NUM_W'(dy) <<< FRAC_BITS;
  assign num_off   = NUM_W'(mul_hold - mul_p);
  assign div_num   = (cmd == CMD_DIV_SLOPE) ? num_slope : num_off;
  assign div_start = (cmd == CMD_DIV_SLOPE) || (cmd == CMD_DIV_OFFSET);

  plc_div #(.NUM_W(NUM_W), .DEN_W(X_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (dx[X_W-1:0]),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // clamp the product term
  assign qc = (hi_big || q_raw > CLAMP) ? CLAMP : q_raw;

  // status to the controller
  always_comb begin
    stat.op         = in_r.operation;
    stat.full       = full;
    stat.few        = pcount < PC_W'(2);
    stat.szero      = scount == '0;
    stat.i_end      = i >= pcount;
    stat.j_zero     = j == '0;
    stat.rd_gt_key  = pt_rd_x > key_x;
    stat.rd_eq_prev = pt_rd_x == prev_x;
    stat.div_done   = div_done;
    stat.q_hit      = (sec_upper >= in_r.x_raw) || (i == PC_W'(scount) - PC_W'(1));
    stat.out_busy   = result_valid && !result_ready;
  end

  // counters and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      pcount       <= '0;
      scount       <= '0;
      result_valid <= 1'b0;
    end else begin
      unique case (cmd)
        CMD_CLEAR:    pcount <= '0;
        CMD_APPEND:   if (!full) pcount <= pcount + PC_W'(1);
        CMD_FEW:      if (pcount == '0) scount <= '0;
        CMD_BUILD_OK: scount <= SC_W'(pcount - PC_W'(1));
        default: ;
      endcase
      if (cmd == CMD_EMIT) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_CAPTURE: begin
        in_r       <= item;
        res_value  <= '0;
        res_valid  <= 1'b0;
        res_status <= ST_OK;
      end
      CMD_APPEND:   if (full) res_status <= ST_FULL;
      CMD_FEW:      res_status <= ST_FEW;
      CMD_SORT_INIT: i <= PC_W'(1);
      CMD_KEY_RD:   j <= i;
      CMD_KEY_LATCH: begin
        key_x <= pt_rd_x;
        key_y <= pt_rd_y;
      end
      CMD_SHIFT:    j <= jm1;
      CMD_INSERT:   i <= i + PC_W'(1);
      CMD_FIRST_RD: i <= PC_W'(1);
      CMD_PREV_LATCH: begin
        prev_x <= pt_rd_x;
        prev_y <= pt_rd_y;
      end
      CMD_CHK_NEXT: begin
        prev_x <= pt_rd_x;
        prev_y <= pt_rd_y;
        i      <= i + PC_W'(1);
      end
      CMD_EQUAL:    res_status <= ST_EQUAL;
      CMD_CUR_LATCH: begin
        cur_x <= pt_rd_x;
        cur_y <= pt_rd_y;
      end
      CMD_MUL1:     mul_p <= prod;
      CMD_MUL2: begin
        mul_hold <= mul_p;
        mul_p    <= prod;
      end
      CMD_SLOPE_LATCH: slope_r <= sat48(div_quo);
      CMD_SEC_WRITE: begin
        prev_x <= cur_x;
        prev_y <= cur_y;
        i      <= i + PC_W'(1);
      end
      CMD_NONE_Q:   res_status <= ST_FEW;
      CMD_Q_INIT:   i <= '0;
      CMD_Q_NEXT:   i <= i + PC_W'(1);
      CMD_Q_PICK: begin
        b_r <= sec_off;
        neg <= (sec_slope < 0) != (in_r.x_raw < 0);
        km  <= (sec_slope < 0) ? K_W'(-sec_slope) : K_W'(sec_slope);
        xm  <= (in_r.x_raw < 0) ? X_W'(-in_r.x_raw) : X_W'(in_r.x_raw);
      end
      CMD_Q_MULHI:  mul_p <= prod;
      CMD_Q_MULLO: begin
        mul_hold <= mul_p;
        mul_p    <= prod;
      end
      CMD_Q_SUM: begin
        hi_big <= Q_W'(mul_hold[2*PART_W-1:0]) > HI_LIM;
        q_raw  <= (Q_W'(mul_hold[2*PART_W-1:0]) << SH)
                + Q_W'(mul_p[2*PART_W-1:0] >> FRAC_BITS);
      end
      CMD_Q_ADD: begin
        r_acc <= neg ? R_W'(b_r) - $signed(R_W'(qc))
                     : R_W'(b_r) + $signed(R_W'(qc));
      end
      CMD_Q_SAT: begin
        res_valid <= 1'b1;
        if (r_acc > S32_HI) begin
          res_value <= S32_HI[V_W-1:0];
        end else if (r_acc < S32_LO) begin
          res_value <= S32_LO[V_W-1:0];
        end else begin
          res_value <= r_acc[V_W-1:0];
        end
      end
      CMD_EMIT: begin
        result.value         <= res_value;
        result.value_valid   <= res_valid;
        result.status        <= res_status;
        result.section_total <= sc_wide[TOT_W-1:0];
      end
      default: ;
    endcase
  end

  `PLC_ASSERT(a_pcount_bound, clk, rst, pcount <= PC_W'(MAX_POINTS))
  `PLC_ASSERT(a_div_start_idle, clk, rst, div_start |-> !div_busy)
  `PLC_ASSERT(a_valid_means_ok, clk, rst, result_valid && result.value_valid |-> result.status == ST_OK)
  `PLC_ASSERT_NR(a_reset_drops_word, clk, rst |=> !result_valid)

endmodule

FILE: src/piecewise_linear_calibrator.sv
// Top level of the piecewise linear calibrator.
//
//   channel  | handshake                   | word
//   ---------+-----------------------------+-------------------------------
//   item     | item_valid / item_ready     | in_word_t  (operation, x, y)
//   result   | result_valid / result_ready | out_word_t (value, status, ..)
//
// One word in at a time. A query scans the section memory until it picks a
// section, then evaluates it. A build runs an insertion sort on the point
// memory, then computes each section, most of it in the two serial divisions.
// Reset clears the counts and the handshake; memories are not cleared.
// A waiting result holds the next word in its finish state only.
module piecewise_linear_calibrator import plc_pkg::*; #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_word_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_word_t result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  plc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  plc_dp #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .item         (item),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
